### design/rpag_pkg.sv
package rpag_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 256;
  localparam int TIDX_W = $clog2(TABLE_ENTRIES);
  localparam int TCNT_W = TIDX_W + 1;
  localparam int CDF_W = 17;

  // Angle constants, Q4.12 and Q28 radians
  localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;
  localparam logic [14:0] TWO_PI_Q12 = 15'd25736;
  localparam logic [29:0] PI_Q28 = 30'd843314857;

  // CORDIC chain sizing
  localparam int CORDIC_STEPS = 16;
  localparam int SHIFT_W = $clog2(CORDIC_STEPS);
  localparam int CX_W = 28;
  localparam int CZ_W = 20;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [CZ_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047, 20'sd1024,
    20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16, 20'sd8, 20'sd4, 20'sd2
  };

  // Interpolation divider sizing
  localparam int PNUM_W = TIDX_W + CDF_W;
  localparam int NPROD_W = PNUM_W + 30;
  localparam int NUM_W = PNUM_W + 31;
  localparam int DEN_W = CDF_W + TIDX_W + 16;
  localparam int QUOT_W = 15;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR_FRACTION = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_FRACTION = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODES = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_ANGLE = 8'd7;

  // Input item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    PAT_RADIAL, PAT_TANGENTIAL, PAT_FIXED, PAT_RANDOM
  } pattern_t;

  typedef enum logic [1:0] {
    REGION_INTERIOR, REGION_RING, REGION_OUTSIDE
  } region_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_DX, ST_MUL_DY, ST_MUL_R1, ST_MUL_R2, ST_MUL_DEF, ST_DECIDE,
    ST_WALK_START, ST_WALK, ST_SEG, ST_NUM_MUL, ST_DIV_START, ST_DIV, ST_FINISH
  } state_t;

  // Data handed from one CORDIC cell to the next
  typedef struct packed {
    logic valid;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cordic_t;

endpackage

### design/rpag_cordic_cell.sv
module rpag_cordic_cell (
  input  logic clk,
  input  logic rst,
  input  logic [rpag_pkg::SHIFT_W-1:0] shift,
  input  logic signed [rpag_pkg::CZ_W-1:0] step_angle,
  input  rpag_pkg::cordic_t din,
  output rpag_pkg::cordic_t dout
);
  import rpag_pkg::*;

  logic valid;
  logic signed [CX_W-1:0] x;
  logic signed [CX_W-1:0] y;
  logic signed [CZ_W-1:0] z;
  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;

  // Arithmetic shifts round toward minus infinity.
  assign xs = din.x >>> shift;
  assign ys = din.y >>> shift;

  // Marker of a live rotation moving down the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= din.valid;
    end
  end

  // One micro-rotation toward y equal to zero; a zero y holds still.
  always_ff @(posedge clk) begin
    if (din.y > 0) begin
      x <= din.x + ys;
      y <= din.y - xs;
      z <= din.z + step_angle;
    end else if (din.y < 0) begin
      x <= din.x - ys;
      y <= din.y + xs;
      z <= din.z - step_angle;
    end else begin
      x <= din.x;
      y <= din.y;
      z <= din.z;
    end
  end

  assign dout = '{valid: valid, x: x, y: y, z: z};

endmodule

### design/rpag_divider.sv
module rpag_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [rpag_pkg::NUM_W-1:0] num,
  input  logic [rpag_pkg::DEN_W-1:0] den,
  output logic done,
  output logic [rpag_pkg::QUOT_W-1:0] quot
);
  import rpag_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;

  // Control: one quotient bit per cycle, done pulses after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(QUOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Restoring division with the divisor walking down from its top position.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NUM_W'(den) << (QUOT_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

### design/ring_polarization_angle_generator.sv
// Ring polarization angle generator. Load transactions (s_tuser low) write one
// entry of the cumulative distribution table. A sample transaction (s_tuser
// high) yields one result: the event is placed in the interior, the ring or
// outside, a polarized fraction test picks the pattern angle or a random one,
// and a modulation offset found by inverse sampling of the table is added.
// The table walk reads the single table memory port once per cycle, walking
// from 1 to 256 table entries. The 16-cell CORDIC chain for the radial angle
// runs alongside the walk, and the interpolation divide follows the walk. No
// new transaction is accepted while a sample is in flight, but a finished
// result may wait in the output register while the next transaction is taken.
// Table entries read before being written give undefined offsets.
module ring_polarization_angle_generator (
  input  logic clk,
  input  logic rst,
  // tdata: table_index[7:0], table_value[24:8], pos_x[40:25], pos_y[56:41],
  //        rnd_default[72:57], rnd_fraction[88:73], rnd_spread[104:89]
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [111:0] s_tdata,
  // tuser: mode[0]
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata: track_angle[15:0]
  output logic [15:0] m_tdata,
  // tuser: region[1:0], polarized[2]
  output logic [2:0] m_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [rpag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [16:0] cfg_data
);
  import rpag_pkg::*;

  // Configuration registers
  logic [15:0] centre_x;
  logic [15:0] centre_y;
  logic [15:0] inner_radius;
  logic [15:0] outer_radius;
  logic [16:0] interior_fraction;
  logic [16:0] ring_fraction;
  logic [3:0] pattern_modes;
  logic signed [15:0] fixed_angle;

  state_t state;
  state_t state_next;

  logic in_acc;
  logic [7:0] in_index;
  logic [16:0] in_value;
  logic [15:0] in_pos_x;
  logic [15:0] in_pos_y;

  // Sample working registers
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [15:0] rdef;
  logic [15:0] rfrac;
  logic [15:0] rspr;
  logic [31:0] dxx;
  logic [31:0] dyy;
  logic [31:0] r1s;
  logic [31:0] r2s;
  logic [14:0] deflt;
  region_t region;
  pattern_t pattern;
  logic pol;
  logic zero_off;

  // Shared multiplier
  logic signed [17:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] mul_p;

  // Decision logic
  logic [32:0] d2;
  region_t region_c;
  pattern_t pattern_c;
  logic [16:0] frac_c;

  // Table memory and walk
  logic [CDF_W-1:0] cdf_mem [TABLE_ENTRIES];
  logic [TIDX_W-1:0] rd_addr;
  logic [CDF_W-1:0] rd_data;
  logic [TCNT_W-1:0] walk_i;
  logic [TCNT_W-1:0] walk_inc;
  logic walk_gt;
  logic walk_stop;
  logic [CDF_W-1:0] lo;
  logic [CDF_W-1:0] hi;

  // Interpolation
  logic [TIDX_W-1:0] seg_base;
  logic [CDF_W-1:0] seg_den;
  logic [CDF_W-1:0] seg_frac;
  logic [CDF_W-1:0] pden;
  logic [PNUM_W-1:0] pnum;
  logic [NPROD_W-1:0] numprod;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] div_num;
  logic div_start;
  logic div_done;
  logic [QUOT_W-1:0] div_q;

  // CORDIC chain
  cordic_t chain [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] x0;
  logic signed [CX_W-1:0] y0;
  logic signed [CZ_W-1:0] cz_sum;
  logic signed [15:0] atan_q12;
  logic cz_done;

  // Result assembly
  logic out_free;
  logic signed [17:0] base_angle;
  logic signed [17:0] offset;
  logic signed [18:0] sum_angle;
  logic signed [15:0] sat_angle;

  assign s_tready = (state == ST_IDLE);
  assign in_acc = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign in_index = s_tdata[7:0];
  assign in_value = s_tdata[24:8];
  assign in_pos_x = s_tdata[40:25];
  assign in_pos_y = s_tdata[56:41];
  assign out_free = !m_tvalid || m_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x <= 16'd0;
      centre_y <= 16'd0;
      inner_radius <= 16'd0;
      outer_radius <= 16'd8000;
      interior_fraction <= 17'd0;
      ring_fraction <= 17'd13107;
      pattern_modes <= 4'd1;
      fixed_angle <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTRE_X: centre_x <= cfg_data[15:0];
        CFG_CENTRE_Y: centre_y <= cfg_data[15:0];
        CFG_INNER_RADIUS: inner_radius <= cfg_data[15:0];
        CFG_OUTER_RADIUS: outer_radius <= cfg_data[15:0];
        CFG_INTERIOR_FRACTION: interior_fraction <= cfg_data;
        CFG_RING_FRACTION: ring_fraction <= cfg_data;
        CFG_PATTERN_MODES: pattern_modes <= cfg_data[3:0];
        CFG_FIXED_ANGLE: fixed_angle <= signed'(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // Table memory: written by load transactions, read by the walk.
  always_ff @(posedge clk) begin
    if (in_acc && (s_tuser == MODE_LOAD) && (int'(in_index) < TABLE_ENTRIES)) begin
      cdf_mem[TIDX_W'(in_index)] <= in_value;
    end
    rd_data <= cdf_mem[rd_addr];
  end

  assign walk_inc = walk_i + 1'b1;
  assign rd_addr = (state == ST_WALK) ? walk_inc[TIDX_W-1:0] : '0;
  assign walk_gt = {1'b0, rspr} > rd_data;
  assign walk_stop = !walk_gt || (walk_i == TCNT_W'(TABLE_ENTRIES - 1));

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_DX: begin
        mul_a = 18'(dx);
        mul_b = 18'(dx);
      end
      ST_MUL_DY: begin
        mul_a = 18'(dy);
        mul_b = 18'(dy);
      end
      ST_MUL_R1: begin
        mul_a = signed'({2'b00, inner_radius});
        mul_b = signed'({2'b00, inner_radius});
      end
      ST_MUL_R2: begin
        mul_a = signed'({2'b00, outer_radius});
        mul_b = signed'({2'b00, outer_radius});
      end
      ST_MUL_DEF: begin
        mul_a = signed'({2'b00, rdef});
        mul_b = signed'({3'b000, TWO_PI_Q12});
      end
      ST_SEG: begin
        mul_a = signed'(18'(seg_base));
        mul_b = signed'({1'b0, seg_den});
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Region, fraction and pattern selection
  always_comb begin
    d2 = {1'b0, dxx} + {1'b0, dyy};
    if (d2 < {1'b0, r1s}) begin
      region_c = REGION_INTERIOR;
      frac_c = interior_fraction;
      pattern_c = pattern_t'(pattern_modes[1:0]);
    end else if ((d2 > {1'b0, r1s}) && (d2 <= {1'b0, r2s})) begin
      region_c = REGION_RING;
      frac_c = ring_fraction;
      pattern_c = pattern_t'(pattern_modes[3:2]);
    end else begin
      region_c = REGION_OUTSIDE;
      frac_c = '0;
      pattern_c = PAT_RADIAL;
    end
  end

  // CORDIC entry: fold the left half plane onto the right one.
  always_comb begin
    x0 = {{(CX_W-25){dx[16]}}, dx, 8'b0};
    y0 = {{(CX_W-25){dy[16]}}, dy, 8'b0};
    chain[0].valid = (state == ST_DECIDE);
    if (x0 < 0) begin
      if (y0 >= 0) begin
        chain[0].x = y0;
        chain[0].y = -x0;
        chain[0].z = HALF_PI_Q16;
      end else begin
        chain[0].x = -y0;
        chain[0].y = x0;
        chain[0].z = -HALF_PI_Q16;
      end
    end else begin
      chain[0].x = x0;
      chain[0].y = y0;
      chain[0].z = '0;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    rpag_cordic_cell u_cell (
      .clk(clk),
      .rst(rst),
      .shift(SHIFT_W'(k)),
      .step_angle(ATAN_Q16[k]),
      .din(chain[k]),
      .dout(chain[k+1])
    );
  end

  assign cz_sum = chain[CORDIC_STEPS].z + CZ_W'(8);

  // Segment of the walk: position base, width and fraction within it.
  always_comb begin
    seg_base = walk_i[TIDX_W-1:0] - 1'b1;
    seg_den = 17'd1;
    seg_frac = '0;
    if (walk_i == '0) begin
      seg_base = '0;
    end else if (walk_i == TCNT_W'(TABLE_ENTRIES)) begin
      seg_base = TIDX_W'(TABLE_ENTRIES - 1);
    end else if (hi > lo) begin
      seg_den = hi - lo;
      seg_frac = {1'b0, rspr} - lo;
    end
  end

  assign den = (DEN_W'(pden) * DEN_W'(TABLE_ENTRIES - 1)) << 16;
  assign div_num = NUM_W'(numprod) + NUM_W'(den >> 1);
  assign div_start = (state == ST_DIV_START);

  rpag_divider u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(den),
    .done(div_done),
    .quot(div_q)
  );

  // Final angle: pattern or random angle plus modulation offset, saturated.
  always_comb begin
    base_angle = signed'({3'b000, deflt});
    if (pol) begin
      unique case (pattern)
        PAT_RADIAL: base_angle = zero_off ? 18'sd0 : 18'(atan_q12);
        PAT_TANGENTIAL: base_angle = (zero_off ? 18'sd0 : 18'(atan_q12)) + HALF_PI_Q12;
        PAT_FIXED: base_angle = 18'(fixed_angle);
        PAT_RANDOM: base_angle = signed'({3'b000, deflt});
      endcase
    end
    offset = signed'({3'b000, div_q}) - HALF_PI_Q12;
    sum_angle = 19'(base_angle) + 19'(offset);
    if (sum_angle > 19'sd32767) begin
      sat_angle = 16'sd32767;
    end else if (sum_angle < -19'sd32768) begin
      sat_angle = -16'sd32768;
    end else begin
      sat_angle = sum_angle[15:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (s_tuser == MODE_SAMPLE)) begin
          state_next = ST_MUL_DX;
        end
      end
      ST_MUL_DX: state_next = ST_MUL_DY;
      ST_MUL_DY: state_next = ST_MUL_R1;
      ST_MUL_R1: state_next = ST_MUL_R2;
      ST_MUL_R2: state_next = ST_MUL_DEF;
      ST_MUL_DEF: state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_WALK_START;
      ST_WALK_START: state_next = ST_WALK;
      ST_WALK: begin
        if (walk_stop) begin
          state_next = ST_SEG;
        end
      end
      ST_SEG: state_next = ST_NUM_MUL;
      ST_NUM_MUL: state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free && cz_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sample datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dx <= signed'({1'b0, in_pos_x}) - signed'({1'b0, centre_x});
      dy <= signed'({1'b0, in_pos_y}) - signed'({1'b0, centre_y});
      rdef <= s_tdata[72:57];
      rfrac <= s_tdata[88:73];
      rspr <= s_tdata[104:89];
    end
    unique case (state)
      ST_MUL_DX: dxx <= mul_p[31:0];
      ST_MUL_DY: dyy <= mul_p[31:0];
      ST_MUL_R1: r1s <= mul_p[31:0];
      ST_MUL_R2: r2s <= mul_p[31:0];
      ST_MUL_DEF: deflt <= mul_p[30:16];
      ST_DECIDE: begin
        region <= region_c;
        pattern <= pattern_c;
        pol <= (region_c != REGION_OUTSIDE) && ({1'b0, rfrac} < frac_c);
        zero_off <= (dx == '0) && (dy == '0);
      end
      ST_WALK_START: walk_i <= '0;
      ST_WALK: begin
        if (walk_stop) begin
          hi <= rd_data;
          if (walk_gt) begin
            walk_i <= walk_inc;
          end
        end else begin
          lo <= rd_data;
          walk_i <= walk_inc;
        end
      end
      ST_SEG: begin
        pnum <= PNUM_W'(mul_p) + PNUM_W'(seg_frac);
        pden <= seg_den;
      end
      ST_NUM_MUL: numprod <= pnum * PI_Q28;
      default: ;
    endcase
    if (chain[CORDIC_STEPS].valid) begin
      atan_q12 <= cz_sum[19:4];
    end
  end

  // CORDIC completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cz_done <= 1'b0;
    end else if (state == ST_DECIDE) begin
      cz_done <= 1'b0;
    end else if (chain[CORDIC_STEPS].valid) begin
      cz_done <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free && cz_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free && cz_done) begin
      m_tdata <= sat_angle;
      m_tuser <= {pol, region};
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rpag_pkg::*;

  // One input transaction as the driver sees it.
  typedef struct {
    logic        kind;
    logic [7:0]  tidx;
    logic [16:0] tval;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] rdef;
    logic [15:0] rfrac;
    logic [15:0] rspread;
  } event_item_t;

  // One expected output transaction.
  typedef struct {
    logic [15:0] angle;
    logic [1:0]  region;
    logic        pol;
  } track_t;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [111:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  ring_polarization_angle_generator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: its own copy of the table and registers.
  logic [16:0] cdf_mirror [TABLE_ENTRIES];
  logic [15:0] ctr_x, ctr_y, rad_in, rad_out;
  logic [16:0] frac_in, frac_ring;
  logic [3:0]  pat_sel;
  logic signed [15:0] fix_ang;

  event_item_t pending_items[$];
  track_t      expected_tracks[$];
  int          errors = 0;
  int          cycles = 0;
  int          samples_seen = 0;
  int          loads_done = 0;
  int          hold_cycles = 0;
  bit          long_hold_done = 1'b0;
  bit          burst_on = 1'b0;
  int          burst_left = 0;
  int          stall_phase = 0;

  function automatic logic signed [63:0] shr_floor(input logic signed [63:0] v,
                                                   input int s);
    shr_floor = v >>> s;
  endfunction

  // CORDIC vectoring in 2^-16 rad, rounded to Q4.12.
  function automatic logic signed [31:0] radial_angle(input logic signed [63:0] dx,
                                                      input logic signed [63:0] dy);
    logic signed [63:0] x, y, z, nx, xs, ys;
    int k;
    int atan_tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
    if (dx == 0 && dy == 0) return 0;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; y = -x; z = 102944;
      end else begin
        nx = -y; y = x; z = -102944;
      end
      x = nx;
    end
    for (k = 0; k < 16; k++) begin
      xs = shr_floor(x, k);
      ys = shr_floor(y, k);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_tab[k];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= atan_tab[k];
      end
    end
    return 32'(shr_floor(z + 8, 4));
  endfunction

  // Inverse sampling of the table with interpolation, Q4.12 offset.
  function automatic logic signed [31:0] modulation_offset(input logic [15:0] r);
    logic [63:0] pnum, pden, num, den;
    logic [16:0] lo, hi;
    int k;
    k = 0;
    while (k < TABLE_ENTRIES && {1'b0, r} > cdf_mirror[k]) k++;
    if (k == 0) begin
      pnum = 0; pden = 1;
    end else if (k >= TABLE_ENTRIES) begin
      pnum = TABLE_ENTRIES - 1; pden = 1;
    end else begin
      lo = cdf_mirror[k-1];
      hi = cdf_mirror[k];
      if (hi > lo) begin
        pden = hi - lo;
        pnum = (k - 1) * pden + (r - lo);
      end else begin
        pnum = k - 1; pden = 1;
      end
    end
    num = pnum * 64'd843314857;
    den = pden * (TABLE_ENTRIES - 1) * 64'd65536;
    return 32'((num + den / 2) / den) - 6434;
  endfunction

  // Expected result of one sample event.
  function automatic track_t predict_track(input event_item_t it);
    track_t t;
    logic signed [63:0] dx, dy, ang, dflt;
    logic [63:0] d2, r1s, r2s;
    logic [16:0] frac;
    logic [1:0] pat;
    dx = $signed({48'd0, it.px}) - $signed({48'd0, ctr_x});
    dy = $signed({48'd0, it.py}) - $signed({48'd0, ctr_y});
    d2 = dx * dx + dy * dy;
    r1s = rad_in * rad_in;
    r2s = rad_out * rad_out;
    dflt = (it.rdef * 64'd25736) >> 16;
    ang = dflt;
    frac = 0;
    pat = 0;
    t.pol = 1'b0;
    if (d2 < r1s) begin
      t.region = REGION_INTERIOR; frac = frac_in; pat = pat_sel[1:0];
    end else if (d2 > r1s && d2 <= r2s) begin
      t.region = REGION_RING; frac = frac_ring; pat = pat_sel[3:2];
    end else begin
      t.region = REGION_OUTSIDE;
    end
    if (t.region != REGION_OUTSIDE && {1'b0, it.rfrac} < frac) begin
      t.pol = 1'b1;
      case (pattern_t'(pat))
        PAT_RADIAL:     ang = radial_angle(dx, dy);
        PAT_TANGENTIAL: ang = radial_angle(dx, dy) + 6434;
        PAT_FIXED:      ang = fix_ang;
        default:        ang = dflt;
      endcase
    end
    ang += modulation_offset(it.rspread);
    if (ang > 32767) ang = 32767;
    if (ang < -32768) ang = -32768;
    t.angle = ang[15:0];
    return t;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Driver: bursts and gaps, prediction at acceptance.
  always @(posedge clk) begin
    event_item_t it;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it = pending_items.pop_front();
        if (it.kind == MODE_LOAD) begin
          cdf_mirror[it.tidx] = it.tval;
          loads_done++;
        end else begin
          expected_tracks.push_back(predict_track(it));
        end
      end
      if (burst_left == 0) begin
        burst_on = !burst_on;
        burst_left = burst_on ? $urandom_range(1, 30) : $urandom_range(0, 6);
      end else begin
        burst_left--;
      end
      if (pending_items.size() > 0 && (burst_on || $urandom_range(0, 3) == 0)
          && !(s_tvalid && !s_tready)) begin
        it = pending_items[0];
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {7'd0, it.rspread, it.rfrac, it.rdef, it.py, it.px, it.tval, it.tidx};
      end else if (!(s_tvalid && !s_tready)) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst) begin
      stall_phase <= (stall_phase + 1) % 23;
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 1'b0;
      end else if (!long_hold_done && samples_seen >= 40 && m_tvalid) begin
        hold_cycles <= 3000;
        long_hold_done <= 1'b1;
        m_tready <= 1'b0;
      end else if (stall_phase < 8) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    track_t e;
    if (!rst && m_tvalid && m_tready) begin
      samples_seen++;
      if (expected_tracks.size() == 0) begin
        errors++;
        $display("%0t unexpected result angle=%h region=%0d pol=%0d",
                 $time, m_tdata, m_tuser[1:0], m_tuser[2]);
      end else begin
        e = expected_tracks.pop_front();
        if (m_tdata !== e.angle) begin
          errors++;
          $display("%0t angle expected %h actual %h", $time, e.angle, m_tdata);
        end
        if (m_tuser[1:0] !== e.region) begin
          errors++;
          $display("%0t region expected %0d actual %0d", $time, e.region, m_tuser[1:0]);
        end
        if (m_tuser[2] !== e.pol) begin
          errors++;
          $display("%0t polarized expected %0d actual %0d", $time, e.pol, m_tuser[2]);
        end
      end
    end
  end

  // Registers are written through the configuration channel at idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CENTRE_X:          ctr_x = val[15:0];
      CFG_CENTRE_Y:          ctr_y = val[15:0];
      CFG_INNER_RADIUS:      rad_in = val[15:0];
      CFG_OUTER_RADIUS:      rad_out = val[15:0];
      CFG_INTERIOR_FRACTION: frac_in = val;
      CFG_RING_FRACTION:     frac_ring = val;
      CFG_PATTERN_MODES:     pat_sel = val[3:0];
      CFG_FIXED_ANGLE:       fix_ang = val[15:0];
      default: ;
    endcase
  endtask

  task automatic add_load(input int idx, input logic [16:0] val);
    event_item_t it;
    it = '{MODE_LOAD, 8'(idx), val, 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 16'($urandom)};
    pending_items.push_back(it);
  endtask

  task automatic add_sample(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] rd, input logic [15:0] rf,
                            input logic [15:0] rs);
    event_item_t it;
    it = '{MODE_SAMPLE, 8'($urandom), 17'($urandom), px, py, rd, rf, rs};
    pending_items.push_back(it);
  endtask

  // Sample near the centre so the region mix stays interesting.
  task automatic add_random_sample();
    logic [15:0] px, py;
    int span;
    span = int'(rad_out) + 64;
    if ($urandom_range(0, 9) == 0) begin
      px = 16'($urandom); py = 16'($urandom);
    end else begin
      px = 16'(int'(ctr_x) + $urandom_range(0, 2 * span) - span);
      py = 16'(int'(ctr_y) + $urandom_range(0, 2 * span) - span);
    end
    add_sample(px, py, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Waits until the block has drained, then a little longer.
  task automatic drain();
    while (pending_items.size() > 0 || expected_tracks.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // A monotone table with random steps, with extra flat segments when flat is set.
  task automatic load_table(input bit flat);
    int acc, k;
    acc = $urandom_range(0, 300);
    for (k = 0; k < TABLE_ENTRIES; k++) begin
      add_load(k, 17'(acc > 65536 ? 65536 : acc));
      if (!(flat && $urandom_range(0, 3) == 0)) acc += $urandom_range(0, 520);
    end
  endtask

  initial begin
    int ph, k;
    ctr_x = 0; ctr_y = 0; rad_in = 0; rad_out = 8000;
    frac_in = 0; frac_ring = 13107; pat_sel = 1; fix_ang = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: full table, then the edge cases.
    load_table(1'b0);
    add_load(300 % 256, 17'd0);
    drain();
    write_reg(CFG_CENTRE_X, 17'd16000);
    write_reg(CFG_CENTRE_Y, 17'd16000);
    write_reg(CFG_INNER_RADIUS, 17'd1000);
    write_reg(CFG_OUTER_RADIUS, 17'd3000);
    write_reg(CFG_INTERIOR_FRACTION, 17'd65536);
    write_reg(CFG_RING_FRACTION, 17'd65536);
    write_reg(CFG_PATTERN_MODES, {13'd0, PAT_TANGENTIAL, PAT_RADIAL});
    write_reg(CFG_FIXED_ANGLE, 17'h08000);
    drain();
    // table reload with the modified entry restored as the predictor sees it
    load_table(1'b1);
    add_sample(16'd16000, 16'd16000, 16'hFFFF, 16'd0, 16'd0);
    add_sample(16'd17000, 16'd16000, 16'h0000, 16'hFFFF, 16'hFFFF);
    add_sample(16'd15000, 16'd16000, 16'hFFFF, 16'd0, 16'h8000);
    add_sample(16'd16000, 16'd18000, 16'h1234, 16'd0, 16'h0001);
    add_sample(16'd16000, 16'd14500, 16'h5555, 16'd0, 16'hAAAA);
    add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    add_sample(16'd16500, 16'd16500, 16'd100, 16'd0, 16'd300);
    drain();

    // Random phases with varied settings; the last ones use extremes.
    for (ph = 0; ph < 8; ph++) begin
      write_reg(CFG_CENTRE_X, ph == 7 ? 17'hFFFF : (ph == 6 ? 17'd0 : 17'($urandom)));
      write_reg(CFG_CENTRE_Y, ph == 7 ? 17'hFFFF : (ph == 6 ? 17'd0 : 17'($urandom)));
      write_reg(CFG_INNER_RADIUS, ph == 6 ? 17'd0 : 17'($urandom_range(0, 4000)));
      write_reg(CFG_OUTER_RADIUS, ph == 7 ? 17'hFFFF : 17'($urandom_range(2000, 8000)));
      write_reg(CFG_INTERIOR_FRACTION, ph == 6 ? 17'd0 : 17'($urandom_range(0, 65536)));
      write_reg(CFG_RING_FRACTION, ph == 7 ? 17'd65536 : 17'($urandom_range(0, 65536)));
      write_reg(CFG_PATTERN_MODES, 17'(ph * 2 + $urandom_range(0, 1)));
      write_reg(CFG_FIXED_ANGLE, ph == 7 ? 17'h07FFF : 17'($urandom_range(0, 65535)));
      if (ph % 3 == 1) load_table(ph % 2);
      for (k = 0; k < 100; k++) begin
        if ($urandom_range(0, 19) == 0) add_load($urandom_range(0, 255), 17'($urandom));
        else add_random_sample();
      end
      drain();
    end

    $display("covered %0d results and %0d table loads over 9 register settings",
             samples_seen, loads_done);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
